### rtl/core/csst_pkg.sv
`default_nettype none

package csst_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = CFG_W + 1;
    localparam int SUM_W  = PIX_W + 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int SOFT_LEVEL    = 8 * 90;
    localparam int CENTRE_SHIFT  = 2;
    localparam int MIN_DIM       = 3;
    localparam int RESET_WIDTH   = 720;
    localparam int RESET_HEIGHT  = 576;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CFG_W-1:0] cfg_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic emit;
        logic last;
        logic filt;
        logic par;
        pix_t pix;
    } stage_ctl_t;

    function automatic pix_t soften(input pix_t up, input pix_t down, input pix_t left,
                                    input pix_t right, input pix_t centre);
        sum_t s;
        pix_t r;
        s = (sum_t'(centre) << CENTRE_SHIFT) + sum_t'(up) + sum_t'(down)
            + sum_t'(left) + sum_t'(right);
        if (s == '0)
        begin
            r = '0;
        end
        else if (s < sum_t'(SOFT_LEVEL))
        begin
            r = pix_t'(1);
        end
        else
        begin
            r = s[SUM_W-1:3];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/csst_row_bank.sv
`default_nettype none

module csst_row_bank #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic            re,
    input  wire logic [AW-1:0]   addr,
    input  wire csst_pkg::pix_t  wdata,
    output csst_pkg::pix_t       rdata
);
    import csst_pkg::*;

    pix_t mem [DEPTH];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/cross_stencil_soften_threshold_core.sv
`default_nettype none

// Five-point cross softening filter for an 8-bit mask image in raster order. Interior pixels
// become a thresholded eighth of the sum of four times the centre plus its four neighbors;
// border rows and columns pass through. The block takes one item per clock while the output
// is not stalled; each result passes the window stage and output register and belongs to the
// pixel one row plus one pixel earlier, so after the frame's pixels width+1 further items
// (drain, or any item once the frame's rows are in) flush the rest, the last carrying tlast.
// The rate is set by the two row-store banks, both read and one written per item at the
// current column. The row store is not cleared after reset and needs no clearing pass.
module cross_stencil_soften_threshold_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire csst_pkg::pix_t               s_tdata,   // [7:0] pixel_in
    input  wire logic                         s_tuser,   // [0] drain
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output csst_pkg::pix_t                    m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // frame_end
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [csst_pkg::APB_AW-1:0]  paddr,
    input  wire logic [csst_pkg::APB_DW-1:0]  pwdata,
    output logic      [csst_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);
    import csst_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    typedef logic [COL_W-1:0] col_t;
    typedef logic [WID_W-1:0] wid_t;

    cfg_t frame_width_reg;
    cfg_t frame_height_reg;
    reg_index_t cfg_index;

    col_t in_col_reg;
    row_t in_row_reg;

    logic s1_valid_reg;
    stage_ctl_t s1_reg;
    stage_ctl_t s0_ctl;

    pix_t win_up_reg;
    pix_t win_left_reg;
    pix_t win_ctr_reg;
    pix_t win_down_reg;

    logic out_valid_reg;
    pix_t out_data_reg;
    logic out_last_reg;

    wid_t eff_w;
    row_t eff_h;
    wid_t col_ext;
    wid_t col_inc;
    logic flush;
    logic s_fire;
    logic take;
    logic s1_go;
    pix_t rd0;
    pix_t rd1;
    pix_t top;
    pix_t mid;
    pix_t soft_val;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cfg_t'(RESET_WIDTH);
            frame_height_reg <= cfg_t'(RESET_HEIGHT);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (32'(frame_width_reg) < MIN_DIM)
        begin
            eff_w = wid_t'(MIN_DIM);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = wid_t'(MAX_WIDTH);
        end
        else
        begin
            eff_w = wid_t'(frame_width_reg);
        end
        if (frame_height_reg < cfg_t'(MIN_DIM))
        begin
            eff_h = row_t'(MIN_DIM);
        end
        else
        begin
            eff_h = row_t'(frame_height_reg);
        end
    end

    assign col_ext = wid_t'(in_col_reg);
    assign col_inc = col_ext + wid_t'(1);
    assign flush   = in_row_reg >= eff_h;

    assign s1_go    = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_fire   = s_tvalid && s_tready;
    assign take     = s_fire && (flush || !s_tuser);

    always_comb
    begin
        s0_ctl.pix  = flush ? '0 : s_tdata;
        s0_ctl.par  = in_row_reg[0];
        s0_ctl.last = in_row_reg > eff_h;
        s0_ctl.emit = (in_row_reg >= row_t'(2))
                      || ((in_row_reg == row_t'(1)) && (in_col_reg != '0));
        s0_ctl.filt = (in_row_reg >= row_t'(2)) && (in_row_reg < eff_h)
                      && (col_ext >= wid_t'(2)) && (col_inc <= eff_w);
    end

    csst_row_bank #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_bank0 (
        .clk   (clk),
        .we    (take && !s0_ctl.par),
        .re    (take),
        .addr  (in_col_reg),
        .wdata (s0_ctl.pix),
        .rdata (rd0)
    );

    csst_row_bank #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_bank1 (
        .clk   (clk),
        .we    (take && s0_ctl.par),
        .re    (take),
        .addr  (in_col_reg),
        .wdata (s0_ctl.pix),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (take)
        begin
            if (s0_ctl.last)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
            end
            else if (col_inc >= eff_w)
            begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + row_t'(1);
            end
            else
            begin
                in_col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= s0_ctl;
        end
    end

    assign top      = s1_reg.par ? rd1 : rd0;
    assign mid      = s1_reg.par ? rd0 : rd1;
    assign soft_val = soften(win_up_reg, win_down_reg, win_left_reg, mid, win_ctr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg   <= '0;
            win_left_reg <= '0;
            win_ctr_reg  <= '0;
            win_down_reg <= '0;
        end
        else if (s1_go)
        begin
            win_up_reg   <= top;
            win_left_reg <= win_ctr_reg;
            win_ctr_reg  <= mid;
            win_down_reg <= s1_reg.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.emit)
        begin
            out_data_reg <= s1_reg.filt ? soft_val : win_ctr_reg;
            out_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_col_reg) < MAX_WIDTH)
        else $error("input column ran past the row store depth");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s0_ctl.last) |=> (in_row_reg == '0 && in_col_reg == '0))
        else $error("counters did not restart after the frame's last item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.emit && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while a result could not leave the window stage");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_reg.emit) |=> out_valid_reg)
        else $error("an emitting item left the window stage without a result");

endmodule

`default_nettype wire

### dv/cross_stencil_soften_threshold_core_tb.sv
`timescale 1ns / 1ps

module cross_stencil_soften_threshold_core_tb;

    import csst_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed
    {
        pix_t pixel;
        logic frame_end;
    } softened_t;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int
    {
        STYLE_UNIFORM,
        STYLE_BINARY,
        STYLE_NEAR_LEVEL,
        STYLE_TINY,
        STYLE_SPARSE
    } pixel_style_t;

    class soften_scoreboard;
        pix_t        line_mem [2*MAX_W];
        pix_t        win [9];
        int unsigned col;
        int unsigned row;
        int unsigned width_reg;
        int unsigned height_reg;
        softened_t   softened_q [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned frames;

        function new();
            foreach (line_mem[i])
            begin
                line_mem[i] = '0;
            end
            foreach (win[i])
            begin
                win[i] = '0;
            end
            col        = 0;
            row        = 0;
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            mismatches = 0;
            checked    = 0;
            frames     = 0;
        endfunction

        function void set_register(reg_index_t idx, int unsigned value);
            if (idx == REG_FRAME_WIDTH)
            begin
                width_reg = value & 12'hFFF;
            end
            else
            begin
                height_reg = value & 12'hFFF;
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_DIM)
            begin
                return MIN_DIM;
            end
            return (width_reg > MAX_W) ? MAX_W : width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        endfunction

        function bit in_flush();
            return row >= eff_height();
        endfunction

        function bit at_frame_start();
            return row == 0 && col == 0;
        endfunction

        function pix_t soften_window();
            int unsigned s;
            s = 4 * int'(win[4]) + int'(win[1]) + int'(win[7]) + int'(win[3]) + int'(win[5]);
            if (s == 0)
            begin
                return '0;
            end
            if (s < SOFT_LEVEL)
            begin
                return pix_t'(1);
            end
            return pix_t'(s >> 3);
        endfunction

        function void note_item(pix_t pix, logic drain);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned par;
            pix_t        top;
            pix_t        mid;
            pix_t        cur;
            bit          flush;
            softened_t   res;
            w     = eff_width();
            h     = eff_height();
            flush = row >= h;
            if (!flush && drain)
            begin
                return;
            end
            cur = flush ? pix_t'(0) : pix;
            c   = (col >= MAX_W) ? MAX_W - 1 : col;
            par = row & 1;
            top = line_mem[par*MAX_W + c];
            mid = line_mem[(par ^ 1)*MAX_W + c];
            line_mem[par*MAX_W + c] = cur;
            win[0] = win[1];
            win[1] = win[2];
            win[3] = win[4];
            win[4] = win[5];
            win[6] = win[7];
            win[7] = win[8];
            win[2] = top;
            win[5] = mid;
            win[8] = cur;
            if (row >= 2 || (row == 1 && c >= 1))
            begin
                res.pixel = win[4];
                if (row >= 2 && c >= 2 && row + 1 <= h && c + 1 <= w)
                begin
                    res.pixel = soften_window();
                end
                res.frame_end = (row > h);
                softened_q.push_back(res);
            end
            if (row > h)
            begin
                col = 0;
                row = 0;
            end
            else if (c + 1 >= w)
            begin
                col = 0;
                row++;
            end
            else
            begin
                col = c + 1;
            end
        endfunction

        function void check_result(pix_t pix, logic last);
            softened_t exp_r;
            if (softened_q.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d frame_end %0b", pix, last);
                mismatches++;
                return;
            end
            exp_r = softened_q.pop_front();
            checked++;
            if (last === 1'b1)
            begin
                frames++;
            end
            if (exp_r.pixel !== pix)
            begin
                $error("pixel_out mismatch: expected %0d, got %0d", exp_r.pixel, pix);
                mismatches++;
            end
            if (exp_r.frame_end !== last)
            begin
                $error("frame_end mismatch: expected %0b, got %0b", exp_r.frame_end, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    pix_t                s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    pix_t                m_tdata;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    soften_scoreboard    sb;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         items_sent;
    int unsigned         settings_run;
    int unsigned         stall_cycles = 0;

    cross_stencil_soften_threshold_core #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
            $display("cross_stencil_soften_threshold_core_tb failed");
            $finish;
        end
    end

    task automatic apb_write(reg_index_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic apb_read_check(reg_index_t idx, int unsigned expected_v);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== APB_DW'(expected_v))
        begin
            $error("%s readback mismatch: expected %0d, got %0d", idx.name(), expected_v, got);
            sb.mismatches++;
        end
    endtask

    task automatic push_item(pix_t pix, logic drain);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drain;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        sb.note_item(pix, drain);
    endtask

    // Once the frame-end result is in, the block is back at a frame start and idle.
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (sb.softened_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_setting(int unsigned w, int unsigned h, int unsigned target,
                               idle_mode_t mode);
        int unsigned  counted;
        pixel_style_t style;
        pix_t         pix;
        logic         drain;
        counted = 0;
        style   = STYLE_UNIFORM;
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_read_check(REG_FRAME_WIDTH, w);
        apb_read_check(REG_FRAME_HEIGHT, h);
        send_idle_pct  = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 35 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 35 : 0;
        settings_run++;
        while (counted < target || !sb.at_frame_start())
        begin
            if (sb.at_frame_start())
            begin
                style = pixel_style_t'($urandom_range(STYLE_SPARSE));
            end
            if (sb.in_flush())
            begin
                drain = 1'($urandom_range(1));
                pix   = pix_t'($urandom_range(255));
            end
            else
            begin
                drain = ($urandom_range(19) == 0);
                case (style)
                    STYLE_BINARY:     pix = $urandom_range(1) ? 8'hFF : 8'h00;
                    STYLE_NEAR_LEVEL: pix = pix_t'($urandom_range(95, 85));
                    STYLE_TINY:       pix = pix_t'($urandom_range(3));
                    STYLE_SPARSE:     pix = ($urandom_range(7) == 0)
                                            ? pix_t'($urandom_range(255)) : pix_t'(0);
                    default:          pix = pix_t'($urandom_range(255));
                endcase
            end
            if (sb.in_flush() || !drain)
            begin
                counted++;
            end
            push_item(pix, drain);
        end
        drain_wait();
    endtask

    initial
    begin
        pix_t edge_frame [15];
        edge_frame = '{8'd255, 8'd0, 8'd0, 8'd90, 8'd0,
                       8'd0,   8'd0, 8'd0, 8'd90, 8'd180,
                       8'd0,   8'd0, 8'd0, 8'd90, 8'd255};
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        settings_run   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read_check(REG_FRAME_WIDTH, RESET_WIDTH);
        apb_read_check(REG_FRAME_HEIGHT, RESET_HEIGHT);

        // A 5x3 frame hitting a zero sum, small sums, the threshold exactly and
        // pass-through borders, with a drain inside the frame and a mixed flush.
        apb_write(REG_FRAME_WIDTH, 5);
        apb_write(REG_FRAME_HEIGHT, 3);
        settings_run++;
        for (int i = 0; i < 15; i++)
        begin
            push_item(edge_frame[i], 1'b0);
            if (i == 7)
            begin
                push_item(8'hAA, 1'b1);
            end
        end
        for (int j = 0; j < 6; j++)
        begin
            push_item(j[0] ? 8'hFF : 8'h00, j[0]);
        end
        drain_wait();

        run_setting(3, 3, 250, IDLE_SENDER);
        run_setting(8, 5, 250, IDLE_RECEIVER);
        run_setting(1, 0, 100, IDLE_BOTH);
        run_setting(13, 7, 200, IDLE_NONE);
        run_setting(3, 60, 100, IDLE_SENDER);
        run_setting(31, 4, 150, IDLE_BOTH);
        run_setting(5, 11, 200, IDLE_RECEIVER);
        run_setting(64, 3, 250, IDLE_NONE);

        repeat (10) @(posedge clk);
        if (sb.softened_q.size() != 0)
        begin
            $error("%0d softened pixels never arrived", sb.softened_q.size());
            sb.mismatches++;
        end
        $display("Accepted %0d items and checked %0d results over %0d frames in %0d sizes.",
                 items_sent, sb.checked, sb.frames, settings_run);
        $display("Frames ran from 3x3 up to 64 wide and 60 high, with undersized registers "
                 , "clamped to 3, under all idle patterns.");
        if (sb.mismatches == 0)
        begin
            $display("cross_stencil_soften_threshold_core_tb passed");
        end
        else
        begin
            $display("cross_stencil_soften_threshold_core_tb failed");
        end
        $finish;
    end

endmodule
